// ----- rtl/xcr_pkg.sv -----
package xcr_pkg;

  // Packet geometry.
  localparam int PAYLOAD_BYTES = 128;
  localparam int WORD_BYTES    = 8;
  localparam int PKT_BYTES     = PAYLOAD_BYTES + 5;
  localparam int WORDS         = PAYLOAD_BYTES / WORD_BYTES;
  localparam int WORD_W        = 8 * WORD_BYTES;
  localparam int POS_W         = $clog2(PKT_BYTES);
  localparam int AW            = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int LANE_W        = (WORD_BYTES > 1) ? $clog2(WORD_BYTES) : 1;
  localparam int QUEUE_DEPTH   = 2;

  // Control characters of the link.
  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_ETB = 8'h17;
  localparam logic [7:0] CH_C   = 8'h43;

  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [7:0]  TIMEOUT_RST = 8'd100;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_BYTE  = 2'd1,
    REQ_POLL  = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    CMD_C      = 2'd0,
    CMD_DONE   = 2'd1,
    CMD_NAK    = 2'd2,
    CMD_STREAM = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] rx_byte;
  } in_beat_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        data_valid;
    logic [63:0] data_word;
    logic [15:0] data_offset;
    logic        transfer_done;
    logic [15:0] received_total;
    logic        last;
  } out_beat_t;

  // Work handed from the front to the back.
  typedef struct packed {
    cmd_e        kind;
    logic [15:0] total;
    logic [15:0] base;
  } cmd_t;

  // CRC-16, MSB first, one byte.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/xcr_ram.sv -----
module xcr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single write port, registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/xcr_queue.sv -----
module xcr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  xcr_pkg::cmd_t push_data_i,
  input  logic          pop_i,
  output xcr_pkg::cmd_t pop_data_o,
  output logic          empty_o,
  output logic          full_o
);
  import xcr_pkg::*;

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          entry_q [QUEUE_DEPTH];
  logic [QW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;

  assign empty_o    = (count_q == '0);
  assign full_o     = (count_q == CW'(QUEUE_DEPTH));
  assign pop_data_o = entry_q[rd_ptr_q];

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/xcr_front.sv -----
module xcr_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [7:0]                 cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  xcr_pkg::in_beat_t          in_data_i,
  input  logic                       queue_full_i,
  output logic                       push_o,
  output xcr_pkg::cmd_t              push_data_o,
  input  logic                       stream_done_i,
  output logic                       ram_we_o,
  output logic [xcr_pkg::AW-1:0]     ram_waddr_o,
  output logic [xcr_pkg::WORD_W-1:0] ram_wdata_o
);
  import xcr_pkg::*;

  logic [POS_W-1:0]  pos_q, pos_d;
  logic [7:0]        blk_q, blk_d;
  logic [15:0]       crc_q, crc_d;
  logic [7:0]        crc_hi_q, crc_hi_d;
  logic [7:0]        last_good_q, last_good_d;
  logic [7:0]        idle_q, idle_d;
  logic [15:0]       total_q, total_d;
  logic              finished_q, finished_d;
  logic [7:0]        timeout_q;
  logic [LANE_W-1:0] lane_q, lane_d;
  logic [AW-1:0]     widx_q, widx_d;
  logic [WORD_W-1:0] word_q, word_d;
  logic              stream_pend_q, stream_pend_d;
  logic [WORD_W-1:0] word_nx;
  logic              in_fire;
  logic [7:0]        b;
  logic              lane_last;

  assign in_ready_o = !queue_full_i && !stream_pend_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign b          = in_data_i.rx_byte;
  assign lane_last  = (lane_q == LANE_W'(WORD_BYTES - 1));

  // Current word with the incoming byte dropped into its lane.
  always_comb begin
    word_nx = word_q;
    word_nx[lane_q * 8 +: 8] = b;
  end

  assign ram_waddr_o = widx_q;
  assign ram_wdata_o = word_nx;

  // Classify the beat, advance framing and decide what the back must do.
  always_comb begin
    pos_d         = pos_q;
    blk_d         = blk_q;
    crc_d         = crc_q;
    crc_hi_d      = crc_hi_q;
    last_good_d   = last_good_q;
    idle_d        = idle_q;
    total_d       = total_q;
    finished_d    = finished_q;
    lane_d        = lane_q;
    widx_d        = widx_q;
    word_d        = word_q;
    stream_pend_d = stream_pend_q && !stream_done_i;
    push_o        = 1'b0;
    push_data_o   = '{kind: CMD_C, total: total_q, base: total_q};
    ram_we_o      = 1'b0;
    if (in_fire) begin
      case (in_data_i.req_type)
        REQ_START: begin
          pos_d       = '0;
          blk_d       = '0;
          crc_d       = '0;
          crc_hi_d    = '0;
          last_good_d = '0;
          idle_d      = '0;
          total_d     = '0;
          finished_d  = 1'b0;
          push_o      = 1'b1;
          push_data_o = '{kind: CMD_C, total: 16'd0, base: 16'd0};
        end
        REQ_BYTE: begin
          if (!finished_q) begin
            idle_d = '0;
            if (pos_q == '0) begin
              if (b == CH_EOT || b == CH_ETB) begin
                finished_d       = 1'b1;
                push_o           = 1'b1;
                push_data_o.kind = CMD_DONE;
              end else if (b == CH_SOH) begin
                crc_d  = '0;
                lane_d = '0;
                widx_d = '0;
                pos_d  = POS_W'(1);
              end
            end else if (pos_q == POS_W'(1)) begin
              blk_d = b;
              pos_d = pos_q + 1'b1;
            end else if (pos_q >= POS_W'(3) && pos_q < POS_W'(3 + PAYLOAD_BYTES)) begin
              crc_d = crc_byte(crc_q, b);
              word_d = word_nx;
              if (lane_last) begin
                ram_we_o = 1'b1;
                lane_d   = '0;
                widx_d   = widx_q + 1'b1;
              end else begin
                lane_d = lane_q + 1'b1;
              end
              pos_d = pos_q + 1'b1;
            end else if (pos_q == POS_W'(3 + PAYLOAD_BYTES)) begin
              crc_hi_d = b;
              pos_d    = pos_q + 1'b1;
            end else if (pos_q >= POS_W'(PKT_BYTES - 1)) begin
              pos_d = '0;
              if ({crc_hi_q, b} == crc_q) begin
                push_o = 1'b1;
                if (blk_q == last_good_q) begin
                  push_data_o.kind = CMD_NAK;
                end else begin
                  last_good_d   = blk_q;
                  total_d       = total_q + 16'(PAYLOAD_BYTES);
                  stream_pend_d = 1'b1;
                  push_data_o   = '{kind: CMD_STREAM,
                                    total: total_q + 16'(PAYLOAD_BYTES),
                                    base: total_q};
                end
              end
            end else begin
              // Block complement: skipped without a check.
              pos_d = pos_q + 1'b1;
            end
          end
        end
        REQ_POLL: begin
          if (!finished_q) begin
            if (idle_q >= timeout_q) begin
              idle_d = '0;
              push_o = 1'b1;
            end else begin
              idle_d = idle_q + 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q         <= '0;
      blk_q         <= '0;
      crc_q         <= '0;
      crc_hi_q      <= '0;
      last_good_q   <= '0;
      idle_q        <= '0;
      total_q       <= '0;
      finished_q    <= 1'b1;
      timeout_q     <= TIMEOUT_RST;
      lane_q        <= '0;
      widx_q        <= '0;
      stream_pend_q <= 1'b0;
    end else begin
      pos_q         <= pos_d;
      blk_q         <= blk_d;
      crc_q         <= crc_d;
      crc_hi_q      <= crc_hi_d;
      last_good_q   <= last_good_d;
      idle_q        <= idle_d;
      total_q       <= total_d;
      finished_q    <= finished_d;
      lane_q        <= lane_d;
      widx_q        <= widx_d;
      stream_pend_q <= stream_pend_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
    end
  end

  // Word assembly register holds payload only.
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  // Framing never runs past the packet, and nothing is queued into a full queue or
  // behind a pending burst.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pos_q <= POS_W'(PKT_BYTES - 1))
    else $error("byte position beyond packet end");
  assert property (@(posedge clk_i) disable iff (!rst_ni) stream_pend_q |-> !push_o)
    else $error("command queued while payload burst pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_o |-> !queue_full_i)
    else $error("command queued while queue full");

endmodule

// ----- rtl/xcr_back.sv -----
module xcr_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       queue_empty_i,
  input  xcr_pkg::cmd_t              pop_data_i,
  output logic                       pop_o,
  output logic                       stream_done_o,
  output logic                       ram_re_o,
  output logic [xcr_pkg::AW-1:0]     ram_raddr_o,
  input  logic [xcr_pkg::WORD_W-1:0] ram_rdata_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output xcr_pkg::out_beat_t         out_data_o
);
  import xcr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_SEND = 3'b100
  } back_state_e;

  back_state_e state_q, state_d;
  logic [AW-1:0] k_q, k_d;
  logic [15:0]   off_q, off_d;
  logic [15:0]   tot_q, tot_d;
  logic          out_valid_q, out_valid_d;
  out_beat_t     out_q, out_nx;
  logic          out_load;
  logic          out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign ram_raddr_o = k_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Command execution: single replies directly, bursts word by word from the RAM.
  always_comb begin
    state_d       = state_q;
    k_d           = k_q;
    off_d         = off_q;
    tot_d         = tot_q;
    pop_o         = 1'b0;
    ram_re_o      = 1'b0;
    stream_done_o = 1'b0;
    out_load      = 1'b0;
    out_nx        = '0;
    case (state_q)
      ST_IDLE: begin
        if (!queue_empty_i && out_free) begin
          pop_o                 = 1'b1;
          out_nx.received_total = pop_data_i.total;
          out_nx.last           = 1'b1;
          out_nx.tx_valid       = 1'b1;
          case (pop_data_i.kind)
            CMD_C: begin
              out_nx.tx_byte = CH_C;
              out_load       = 1'b1;
            end
            CMD_DONE: begin
              out_nx.tx_byte       = CH_ACK;
              out_nx.transfer_done = 1'b1;
              out_load             = 1'b1;
            end
            CMD_NAK: begin
              out_nx.tx_byte = CH_NAK;
              out_load       = 1'b1;
            end
            CMD_STREAM: begin
              k_d     = '0;
              off_d   = pop_data_i.base;
              tot_d   = pop_data_i.total;
              state_d = ST_READ;
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        ram_re_o = 1'b1;
        state_d  = ST_SEND;
      end
      ST_SEND: begin
        if (out_free) begin
          out_load              = 1'b1;
          out_nx.data_valid     = 1'b1;
          out_nx.data_word      = 64'(ram_rdata_i);
          out_nx.data_offset    = off_q;
          out_nx.received_total = tot_q;
          if (k_q == AW'(WORDS - 1)) begin
            out_nx.tx_valid = 1'b1;
            out_nx.tx_byte  = CH_ACK;
            out_nx.last     = 1'b1;
            stream_done_o   = 1'b1;
            state_d         = ST_IDLE;
          end else begin
            k_d     = k_q + 1'b1;
            off_d   = off_q + 16'(WORD_BYTES);
            state_d = ST_READ;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register decouples the result side.
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q <= off_d;
    tot_q <= tot_d;
    if (out_load) begin
      out_q <= out_nx;
    end
  end

  // A data beat carries the reply exactly on the final word of the burst.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.data_valid |-> (out_q.last == out_q.tx_valid))
    else $error("burst reply not on final word");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stream_done_o |=> state_q == ST_IDLE)
    else $error("burst end did not return to idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> state_q == ST_IDLE)
    else $error("command taken during a burst");

endmodule

// ----- rtl/xmodem_crc_receiver.sv -----
// XMODEM-CRC receiver. A reply passes through the command queue and the output register
// after its input beat is accepted; a good block's payload words pass through the read
// and send states and the output register. One input beat per cycle while the command
// queue has room and no payload burst is pending; a good new block holds off input until
// its burst is sent. Reset (asynchronous, active low) clears framing state, sets the
// idle-until-start flag and loads the timeout register with 100; the payload RAM is not cleared.
module xmodem_crc_receiver (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  xcr_pkg::in_beat_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output xcr_pkg::out_beat_t  out_data_o
);
  import xcr_pkg::*;

  logic              push;
  cmd_t              push_data;
  logic              pop;
  cmd_t              pop_data;
  logic              q_empty;
  logic              q_full;
  logic              stream_done;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  xcr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_data_i     (in_data_i),
    .queue_full_i  (q_full),
    .push_o        (push),
    .push_data_o   (push_data),
    .stream_done_i (stream_done),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata)
  );

  xcr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  xcr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  xcr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .queue_empty_i (q_empty),
    .pop_data_i    (pop_data),
    .pop_o         (pop),
    .stream_done_o (stream_done),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (out_data_o)
  );

endmodule
